[src/arrt_pkg.sv]
package arrt_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int WORD_W  = 64;

  // opcodes
  localparam logic [1:0] OP_TRACK   = 2'd0;
  localparam logic [1:0] OP_UNTRACK = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  // status codes
  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t base;
    word_t owner;
    word_t length;
  } entry_t;

endpackage

[src/arrt_req_if.sv]
interface arrt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  arrt_pkg::word_t    address;
  arrt_pkg::word_t    object_key;
  arrt_pkg::word_t    region_size;

  modport source (output valid, output opcode, output address, output object_key,
                  output region_size, input ready);
  modport sink   (input valid, input opcode, input address, input object_key,
                  input region_size, output ready);
endinterface

[src/arrt_rsp_if.sv]
interface arrt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic               found;
  arrt_pkg::word_t    hit_key;
  arrt_pkg::word_t    hit_offset;

  modport source (output valid, output status, output found, output hit_key,
                  output hit_offset, input ready);
  modport sink   (input valid, input status, input found, input hit_key,
                  input hit_offset, output ready);
endinterface

[src/address_range_region_table_top.sv]
// Address region table: up to 32 regions (base, length, owner key) kept in insertion
// order in a single-port-read, single-port-write memory. Track replaces any entry of
// the same key and appends; untrack removes by key and compacts; lookup returns the
// containing region with the greatest base (latest entry on ties) and the offset.
// One item at a time. A scan reads the entries one by one through a single compare/subtract
// unit, drains the read pipeline and then loads the result into the output register.
// Track adds an append step after its scan; ignored items (zero fields, untrack of key 0,
// unused opcode) skip the scan and go straight to the result. The input is ready again in
// the cycle the result appears; a result left waiting holds the next item in its last
// cycle.
module address_range_region_table_top (
  input  logic       clk,
  input  logic       rst,
  arrt_req_if.sink   req,
  arrt_rsp_if.source rsp
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPEND, S_DONE} state_t;

  state_t                state;
  logic [1:0]            op;
  arrt_pkg::word_t       addr;
  arrt_pkg::word_t       key;
  arrt_pkg::word_t       size;
  arrt_pkg::cnt_t        count;
  arrt_pkg::cnt_t        rd_addr;
  logic                  dv;
  arrt_pkg::idx_t        didx;
  logic                  hit;
  arrt_pkg::word_t       best_base;
  arrt_pkg::word_t       res_key;
  arrt_pkg::word_t       res_off;
  logic [1:0]            res_status;

  logic                  out_valid;
  logic                  out_load;
  logic [1:0]            out_status;
  logic                  out_found;
  arrt_pkg::word_t       out_key;
  arrt_pkg::word_t       out_off;

  arrt_pkg::entry_t      mem [arrt_pkg::ENTRIES];
  arrt_pkg::entry_t      rdata;
  logic                  mem_re;
  logic                  mem_we;
  arrt_pkg::idx_t        mem_waddr;
  arrt_pkg::entry_t      mem_wdata;

  logic [arrt_pkg::WORD_W:0] diff;
  logic                  contains;
  logic                  better;
  logic                  key_match;
  logic                  scan_end;
  logic                  has_room;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.found      = out_found;
  assign rsp.hit_key    = out_key;
  assign rsp.hit_offset = out_off;

  // shared compare unit on the entry just read
  assign diff      = {1'b0, addr} - {1'b0, rdata.base};
  assign contains  = !diff[arrt_pkg::WORD_W] && (diff[arrt_pkg::WORD_W-1:0] < rdata.length);
  assign better    = contains && (!hit || (rdata.base >= best_base));
  assign key_match = (rdata.owner == key);
  assign has_room  = (count < arrt_pkg::CNT_W'(arrt_pkg::ENTRIES));

  assign mem_re   = (state == S_SCAN) && (rd_addr < count);
  assign scan_end = (state == S_SCAN) && (rd_addr == count) && !dv;
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // table writes: compaction (once the key is found, each later entry moves down one slot) and the track append
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = didx - arrt_pkg::IDX_W'(1);
    mem_wdata = rdata;
    if (state == S_SCAN && dv && hit && op != arrt_pkg::OP_LOOKUP) begin
      mem_we = 1'b1;
    end else if (state == S_APPEND && has_room) begin
      mem_we    = 1'b1;
      mem_waddr = count[arrt_pkg::IDX_W-1:0];
      mem_wdata = '{base: addr, owner: key, length: size};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[rd_addr[arrt_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dv   <= mem_re;
      didx <= rd_addr[arrt_pkg::IDX_W-1:0];
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.opcode;
            addr       <= req.address;
            key        <= req.object_key;
            size       <= req.region_size;
            hit        <= 1'b0;
            best_base  <= '0;
            res_key    <= '0;
            res_off    <= '0;
            rd_addr    <= '0;
            res_status <= arrt_pkg::ST_IGNORED;
            case (req.opcode)
              arrt_pkg::OP_TRACK: begin
                if (req.address != '0 && req.object_key != '0 && req.region_size != '0)
                  state <= S_SCAN;
                else
                  state <= S_DONE;
              end
              arrt_pkg::OP_UNTRACK: begin
                state <= (req.object_key != '0) ? S_SCAN : S_DONE;
              end
              arrt_pkg::OP_LOOKUP: begin
                state <= S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (mem_re) begin
            rd_addr <= rd_addr + arrt_pkg::CNT_W'(1);
          end
          if (dv) begin
            if (op == arrt_pkg::OP_LOOKUP) begin
              if (better) begin
                hit       <= 1'b1;
                best_base <= rdata.base;
                res_key   <= rdata.owner;
                res_off   <= diff[arrt_pkg::WORD_W-1:0];
              end
            end else if (!hit && key_match) begin
              hit <= 1'b1;
            end
          end
          if (scan_end) begin
            case (op)
              arrt_pkg::OP_LOOKUP: begin
                res_status <= arrt_pkg::ST_APPLIED;
                state      <= S_DONE;
              end
              arrt_pkg::OP_UNTRACK: begin
                res_status <= hit ? arrt_pkg::ST_APPLIED : arrt_pkg::ST_IGNORED;
                if (hit) count <= count - arrt_pkg::CNT_W'(1);
                state <= S_DONE;
              end
              default: begin
                if (hit) count <= count - arrt_pkg::CNT_W'(1);
                state <= S_APPEND;
              end
            endcase
          end
        end
        S_APPEND: begin
          if (has_room) begin
            count      <= count + arrt_pkg::CNT_W'(1);
            res_status <= arrt_pkg::ST_APPLIED;
          end else begin
            res_status <= arrt_pkg::ST_FULL;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_status <= res_status;
            out_found  <= hit && (op == arrt_pkg::OP_LOOKUP);
            out_key    <= (op == arrt_pkg::OP_LOOKUP) ? res_key : '0;
            out_off    <= (op == arrt_pkg::OP_LOOKUP) ? res_off : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= arrt_pkg::CNT_W'(arrt_pkg::ENTRIES))
    else $error("entry count above table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("input ready right after an accepted item");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SCAN || state == S_APPEND))
    else $error("table write outside scan or append");

  a_found_applied: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.found) |-> (rsp.status == arrt_pkg::ST_APPLIED))
    else $error("hit reported with non-applied status");

endmodule
